### hw/rtl/sorted_priority_queue_defines.svh
// Assertion macros used by the sorted priority queue top level.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, skipped while reset is asserted.
`define SPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("spq assertion failed");
// Checked property that also holds through reset.
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("spq assertion failed");
`else
`define SPQ_ASSERT(lbl, clk, rst_n, prop)
`define SPQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

### hw/rtl/spq_pkg.sv
// Types and constants of the sorted priority queue.
package spq_pkg;

    localparam int QUEUE_DEPTH   = 8;
    localparam int PRIORITY_BITS = 16;
    localparam int PAYLOAD_BITS  = 32;
    localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
    localparam int STATUS_W      = 2;

    localparam int IN_FIELD_W  = PRIORITY_BITS + PAYLOAD_BITS;
    localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = PRIORITY_BITS + PAYLOAD_BITS + CNT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [PRIORITY_BITS-1:0] prio;
        logic [PAYLOAD_BITS-1:0]         payload;
    } t_entry;

    // Broadcast from the control to every cell.
    typedef struct packed {
        logic   upd;        // queue changes this cycle
        logic   deq;        // shift toward head instead of insert
        t_entry new_entry;  // entry being enqueued
    } t_cell_ctrl;

endpackage

### hw/rtl/spq_cell.sv
// One slot of the sorted queue: holds an entry, shifts or inserts.
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occupied,
    input  spq_pkg::t_entry     i_left,
    input  logic                i_left_ins,
    input  spq_pkg::t_entry     i_right,
    output spq_pkg::t_entry     o_entry,
    output logic                o_ins
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // New entry lands at or before this slot: slot free or strictly lower priority.
    assign o_ins = !i_occupied || (r_entry.prio < i_ctrl.new_entry.prio);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.upd) begin
            if (i_ctrl.deq) begin
                n_entry = i_right;
            end else if (o_ins && i_left_ins) begin
                n_entry = i_left;
            end else if (o_ins) begin
                n_entry = i_ctrl.new_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

### hw/rtl/sorted_priority_queue.sv
// Sorted priority queue: top level with control, cell chain and output register.
//
// Usage
//   Slave channel (i_s_*) takes one command item per handshake. tuser[0] is the
//   command (0 enqueue, 1 dequeue); tdata carries the priority in bits 15:0
//   (signed) and the payload tag in bits 47:16, used only by an enqueue.
//   Master channel (o_m_*) returns exactly one result item per command: status
//   in tuser (0 done, 1 full, 2 empty), and in tdata the dequeued priority,
//   payload and the occupancy after the command. Priority and payload are zero
//   unless a dequeue succeeded.
//   Entries leave by descending priority; equal priorities leave in arrival order.
// Timing
//   The result is registered and valid in the cycle after acceptance. Every slot
//   of the chain updates in parallel on acceptance (compare against the new priority
//   and shift one step), so a new item can be taken every cycle; throughput is one
//   item per cycle while the receiver keeps tready high.
// Reset and stalls
//   i_rst_n (synchronous, active low) empties the queue and drops any pending
//   result; slot contents are not cleared and need not be. When the receiver
//   stalls, the result is held in the output register and o_s_tready falls
//   until it is taken.
module sorted_priority_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [spq_pkg::IN_DATA_W-1:0]  i_s_tdata,   // priority_req, payload
    input  logic [0:0]                     i_s_tuser,   // command
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [spq_pkg::OUT_DATA_W-1:0] o_m_tdata,   // out_priority, out_payload,
                                                        // occupancy, zero pad
    output logic [spq_pkg::STATUS_W-1:0]   o_m_tuser    // status
);

    `include "sorted_priority_queue_defines.svh"

    localparam int D = spq_pkg::QUEUE_DEPTH;

    logic                         w_acc;
    spq_pkg::t_cmd                w_cmd;
    logic                         w_full;
    logic                         w_empty;
    spq_pkg::t_cell_ctrl          w_ctrl;
    spq_pkg::t_entry              w_entry [D];
    logic                         w_ins   [D];

    logic [spq_pkg::CNT_W-1:0]    r_count;
    logic [spq_pkg::CNT_W-1:0]    n_count;
    logic                         r_m_valid;
    spq_pkg::t_status             r_status;
    spq_pkg::t_status             n_status;
    spq_pkg::t_entry              r_out;
    spq_pkg::t_entry              n_out;

    // Output register: a new item may enter when the slot is free or drains now.
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_cmd      = spq_pkg::t_cmd'(i_s_tuser[0]);
    assign w_full     = (r_count == spq_pkg::CNT_W'(D));
    assign w_empty    = (r_count == '0);

    // Control broadcast to the chain.
    always_comb begin
        w_ctrl.deq               = (w_cmd == spq_pkg::CMD_DEQ);
        w_ctrl.new_entry.prio    = i_s_tdata[spq_pkg::PRIORITY_BITS-1:0];
        w_ctrl.new_entry.payload =
            i_s_tdata[spq_pkg::PRIORITY_BITS +: spq_pkg::PAYLOAD_BITS];
        w_ctrl.upd               = w_acc && (w_ctrl.deq ? !w_empty : !w_full);
    end

    // Chain of slots, head at index 0.
    for (genvar gi = 0; gi < D; gi++) begin : g_cell
        spq_pkg::t_entry w_left;
        spq_pkg::t_entry w_right;
        logic            w_left_ins;

        if (gi == 0) begin : g_head
            assign w_left     = w_ctrl.new_entry;
            assign w_left_ins = 1'b0;
        end else begin : g_body
            assign w_left     = w_entry[gi-1];
            assign w_left_ins = w_ins[gi-1];
        end

        if (gi == D - 1) begin : g_tail
            assign w_right = w_entry[gi];
        end else begin : g_mid
            assign w_right = w_entry[gi+1];
        end

        spq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_occupied (spq_pkg::CNT_W'(gi) < r_count),
            .i_left     (w_left),
            .i_left_ins (w_left_ins),
            .i_right    (w_right),
            .o_entry    (w_entry[gi]),
            .o_ins      (w_ins[gi])
        );
    end

    // Result and occupancy for the accepted item.
    always_comb begin
        n_count  = r_count;
        n_status = spq_pkg::ST_DONE;
        n_out    = '0;
        if (w_ctrl.deq) begin
            if (w_empty) begin
                n_status = spq_pkg::ST_EMPTY;
            end else begin
                n_out   = w_entry[0];
                n_count = r_count - spq_pkg::CNT_W'(1);
            end
        end else begin
            if (w_full) begin
                n_status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + spq_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= n_status;
            r_out    <= n_out;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = spq_pkg::OUT_DATA_W'({r_count, r_out.payload, r_out.prio});

    // Occupancy never goes past the number of slots.
    `SPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= spq_pkg::CNT_W'(D))
    // Enqueue into a full queue reports full and leaves occupancy alone.
    `SPQ_ASSERT(a_full_reject, i_clk, i_rst_n,
        (w_acc && w_cmd == spq_pkg::CMD_ENQ && w_full) |=>
        (o_m_tuser == spq_pkg::ST_FULL && r_count == spq_pkg::CNT_W'(D)))
    // Dequeue from an empty queue reports empty with zeroed data.
    `SPQ_ASSERT(a_empty_reject, i_clk, i_rst_n,
        (w_acc && w_cmd == spq_pkg::CMD_DEQ && w_empty) |=>
        (o_m_tuser == spq_pkg::ST_EMPTY && r_out == '0 && r_count == '0))
    // A successful enqueue grows the queue by exactly one.
    `SPQ_ASSERT(a_enq_grow, i_clk, i_rst_n,
        (w_acc && w_cmd == spq_pkg::CMD_ENQ && !w_full) |=>
        (r_count == $past(r_count) + spq_pkg::CNT_W'(1)))

endmodule
